[hw/rtl/slsi_pkg.sv]
package slsi_pkg;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_GET    = 2'd1,
        OP_RM_AT  = 2'd2,
        OP_RM_VAL = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_APPLY
    } t_state;

    localparam logic [5:0] CAPACITY_RESET = 6'd5;

    typedef struct packed {
        logic eval;
        logic scan;
        logic do_ins;
        logic do_rm;
        t_op  op;
    } t_cell_ctl;

endpackage

[hw/rtl/slsi_cell.sv]
module slsi_cell
    import slsi_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int CW         = 6,
    parameter int PW         = 5,
    parameter int CELL_IDX   = 0
) (
    input  logic                         i_clk,
    input  t_cell_ctl                    i_ctl,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    input  logic        [PW-1:0]         i_index,
    input  logic        [CW-1:0]         i_count,
    input  logic        [PW-1:0]         i_rm_pos,
    input  logic signed [DATA_WIDTH-1:0] i_left_data,
    input  logic                         i_left_ins,
    input  logic signed [DATA_WIDTH-1:0] i_right_data,
    input  logic                         i_c_hit,
    input  logic signed [DATA_WIDTH-1:0] i_c_data,
    input  logic        [PW-1:0]         i_c_pos,
    output logic signed [DATA_WIDTH-1:0] o_data,
    output logic                         o_ins,
    output logic                         o_c_hit,
    output logic signed [DATA_WIDTH-1:0] o_c_data,
    output logic        [PW-1:0]         o_c_pos
);

    localparam logic [CW-1:0] MY_IDX = CW'(CELL_IDX);
    localparam logic [PW-1:0] MY_POS = PW'(CELL_IDX);

    logic signed [DATA_WIDTH-1:0] r_data;
    logic                         r_ins;
    logic                         r_hit;
    logic                         r_c_hit;
    logic signed [DATA_WIDTH-1:0] r_c_data;
    logic        [PW-1:0]         r_c_pos;

    logic occupied;
    logic ins_now;
    logic hit_now;

    assign occupied = MY_IDX < i_count;
    assign ins_now  = (occupied && (i_value <= r_data)) || (MY_IDX == i_count);

    always_comb begin
        unique case (i_ctl.op)
            OP_GET, OP_RM_AT: hit_now = (MY_POS == i_index);
            OP_RM_VAL:        hit_now = occupied && (r_data == i_value);
            default:          hit_now = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.eval) begin
            r_ins   <= ins_now;
            r_hit   <= hit_now;
            r_c_hit <= 1'b0;
        end
        if (i_ctl.scan) begin
            r_c_hit  <= r_hit | i_c_hit;
            r_c_data <= r_hit ? r_data : i_c_data;
            r_c_pos  <= r_hit ? MY_POS : i_c_pos;
        end
        if (i_ctl.do_ins && r_ins) begin
            r_data <= i_left_ins ? i_left_data : i_value;
        end else if (i_ctl.do_rm && (MY_POS >= i_rm_pos)) begin
            r_data <= i_right_data;
        end
    end

    assign o_data   = r_data;
    assign o_ins    = r_ins;
    assign o_c_hit  = r_c_hit;
    assign o_c_data = r_c_data;
    assign o_c_pos  = r_c_pos;

endmodule

[hw/rtl/sorted_list_insert_remove.sv]
// channel   | handshake                  | payload
// ----------+----------------------------+----------------------------------------
// command   | start, busy                | i_operation, i_value, i_index
// result    | o_done (one-cycle strobe)  | o_status, o_data, o_position, o_count
// config    | i_cfg_valid, o_cfg_ready   | i_cfg_data (capacity)
//
// a rejected add, get or remove-at is answered from the evaluate state; a successful add
// passes through evaluate and apply.
// get, remove-at and remove-value pass through evaluate, scan and apply: the result walks down
// the cell chain one cell per cycle from the last cell to cell 0.
// busy is high from accept until the result strobe; a new command may be taken
// in the strobe cycle. reset empties the list and sets capacity to 5.
// results are never held off by the receiver.
module sorted_list_insert_remove
    import slsi_pkg::*;
#(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_operation,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    input  logic [7:0]                   i_index,
    output logic                         o_done,
    output logic [1:0]                   o_status,
    output logic signed [DATA_WIDTH-1:0] o_data,
    output logic [4:0]                   o_position,
    output logic [5:0]                   o_count,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [5:0]                   i_cfg_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW = (CW > 8) ? CW : 8;
    localparam logic [CW-1:0] SCAN_LAST = CW'(DEPTH - 1);
    localparam logic [KW-1:0] DEPTH_K   = KW'(DEPTH);

    t_state                       r_state, n_state;
    t_op                          r_op, n_op;
    logic signed [DATA_WIDTH-1:0] r_value, n_value;
    logic [7:0]                   r_index, n_index;
    logic [CW-1:0]                r_count, n_count;
    logic [CW-1:0]                r_scan, n_scan;
    logic [5:0]                   r_capacity;
    logic                         r_done, n_done;
    t_status                      r_status, n_status;
    logic signed [DATA_WIDTH-1:0] r_res_data, n_res_data;
    logic [4:0]                   r_res_pos, n_res_pos;

    logic signed [DATA_WIDTH-1:0] w_data  [DEPTH];
    logic                         w_ins   [DEPTH];
    logic                         w_chit  [DEPTH];
    logic signed [DATA_WIDTH-1:0] w_cdata [DEPTH];
    logic [PW-1:0]                w_cpos  [DEPTH];

    t_cell_ctl     ctl;
    logic [KW-1:0] cap_x;
    logic [KW-1:0] cap_eff;
    logic [KW-1:0] idx_k;
    logic [KW-1:0] cnt_k;
    logic [PW-1:0] idx_p;
    logic          full;
    logic          idx_ok;

    assign cap_x   = KW'(r_capacity);
    assign cap_eff = (cap_x > DEPTH_K) ? DEPTH_K : cap_x;
    assign idx_k   = KW'(r_index);
    assign cnt_k   = KW'(r_count);
    assign idx_p   = PW'(idx_k);
    assign full    = (cnt_k >= cap_eff) || (cnt_k >= DEPTH_K);
    assign idx_ok  = (idx_k < cap_eff) && (idx_k < cnt_k);

    assign ctl.eval   = (r_state == S_EVAL);
    assign ctl.scan   = (r_state == S_SCAN);
    assign ctl.do_ins = (r_state == S_APPLY) && (r_op == OP_ADD);
    assign ctl.do_rm  = (r_state == S_APPLY)
                     && ((r_op == OP_RM_AT) || ((r_op == OP_RM_VAL) && w_chit[0]));
    assign ctl.op     = r_op;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_WIDTH-1:0] left_data;
        logic                         left_ins;
        logic signed [DATA_WIDTH-1:0] right_data;
        logic                         c_hit_in;
        logic signed [DATA_WIDTH-1:0] c_data_in;
        logic [PW-1:0]                c_pos_in;

        if (g == 0) begin : g_first
            assign left_data = r_value;
            assign left_ins  = 1'b0;
        end else begin : g_mid
            assign left_data = w_data[g-1];
            assign left_ins  = w_ins[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_data = w_data[g];
            assign c_hit_in   = 1'b0;
            assign c_data_in  = '0;
            assign c_pos_in   = '0;
        end else begin : g_inner
            assign right_data = w_data[g+1];
            assign c_hit_in   = w_chit[g+1];
            assign c_data_in  = w_cdata[g+1];
            assign c_pos_in   = w_cpos[g+1];
        end

        slsi_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CW         (CW),
            .PW         (PW),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_value      (r_value),
            .i_index      (idx_p),
            .i_count      (r_count),
            .i_rm_pos     (w_cpos[0]),
            .i_left_data  (left_data),
            .i_left_ins   (left_ins),
            .i_right_data (right_data),
            .i_c_hit      (c_hit_in),
            .i_c_data     (c_data_in),
            .i_c_pos      (c_pos_in),
            .o_data       (w_data[g]),
            .o_ins        (w_ins[g]),
            .o_c_hit      (w_chit[g]),
            .o_c_data     (w_cdata[g]),
            .o_c_pos      (w_cpos[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_scan     <= '0;
            r_capacity <= CAPACITY_RESET;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_scan  <= n_scan;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_value    <= n_value;
        r_index    <= n_index;
        r_status   <= n_status;
        r_res_data <= n_res_data;
        r_res_pos  <= n_res_pos;
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_value    = r_value;
        n_index    = r_index;
        n_count    = r_count;
        n_scan     = r_scan;
        n_done     = 1'b0;
        n_status   = r_status;
        n_res_data = r_res_data;
        n_res_pos  = r_res_pos;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = t_op'(i_operation);
                    n_value = i_value;
                    n_index = i_index;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_scan     = '0;
                n_res_data = '0;
                n_res_pos  = '0;
                unique case (r_op)
                    OP_ADD: begin
                        if (full) begin
                            n_status = ST_FULL;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_state = S_APPLY;
                        end
                    end
                    OP_GET, OP_RM_AT: begin
                        if (idx_ok) begin
                            n_state = S_SCAN;
                        end else begin
                            n_status = ST_RANGE;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                    OP_RM_VAL: begin
                        n_state = S_SCAN;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                n_scan = r_scan + 1'b1;
                if (r_scan == SCAN_LAST) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_done     = 1'b1;
                n_state    = S_IDLE;
                n_status   = ST_OK;
                n_res_data = '0;
                n_res_pos  = '0;
                unique case (r_op)
                    OP_ADD: begin
                        n_count = r_count + 1'b1;
                    end
                    OP_GET: begin
                        n_res_data = w_cdata[0];
                    end
                    OP_RM_AT: begin
                        n_res_data = w_cdata[0];
                        n_count    = r_count - 1'b1;
                    end
                    OP_RM_VAL: begin
                        if (w_chit[0]) begin
                            n_res_data = w_cdata[0];
                            n_res_pos  = 5'(w_cpos[0]);
                            n_count    = r_count - 1'b1;
                        end else begin
                            n_status = ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_data      = r_res_data;
    assign o_position  = r_res_pos;
    assign o_count     = 6'(r_count);

`ifndef SYNTHESIS
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_state) == S_APPLY || $past(r_state) == S_EVAL))
        else $error("result strobe without a finished command");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        KW'(r_count) <= DEPTH_K)
        else $error("entry count above depth");

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_EVAL))
        else $error("accepted transaction did not start evaluation");

    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_op == OP_ADD && r_status == ST_OK && $past(r_state) == S_APPLY)
        |-> (r_count == $past(r_count) + 1'b1))
        else $error("add did not grow the list by one");
`endif

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
    import slsi_pkg::*;

    localparam int DEPTH      = 32;
    localparam int DATA_WIDTH = 32;
    localparam int N_RANDOM   = 1750;

    typedef struct packed {
        t_status           status;
        logic signed [31:0] data;
        logic [4:0]        position;
        logic [5:0]        count;
    } t_result;

    typedef struct packed {
        logic        is_cfg;
        t_op         op;
        logic [31:0] value;
        logic [7:0]  index;
        logic        typed;
        t_result     want;
    } t_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic [1:0]  i_operation = 2'd0;
    logic signed [DATA_WIDTH-1:0] i_value = '0;
    logic [7:0]  i_index     = 8'd0;
    logic        i_cfg_valid = 1'b0;
    logic [5:0]  i_cfg_data  = 6'd0;

    logic        busy;
    logic        o_done;
    logic [1:0]  o_status;
    logic signed [DATA_WIDTH-1:0] o_data;
    logic [4:0]  o_position;
    logic [5:0]  o_count;
    logic        o_cfg_ready;

    // predictor state
    logic signed [31:0] list_mem [DEPTH];
    int                 list_len = 0;
    logic [5:0]         cap_reg  = CAPACITY_RESET;

    t_result pending [$];
    int      errors = 0;
    bit      steady = 1'b0;

    sorted_list_insert_remove #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_index     (i_index),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_data      (o_data),
        .o_position  (o_position),
        .o_count     (o_count),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    task automatic flag(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        errors++;
    endtask

    function automatic void drop_entry(int p);
        for (int i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
        list_len--;
    endfunction

    function automatic t_result list_apply(t_op op, logic signed [31:0] v, logic [7:0] idx);
        t_result res;
        int      lim;
        int      p;
        lim = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
        res = '0;
        res.status = ST_OK;
        case (op)
            OP_ADD: begin
                if (list_len >= lim) begin
                    res.status = ST_FULL;
                end else begin
                    p = list_len;
                    for (int i = 0; i < list_len; i++) begin
                        if (v <= list_mem[i]) begin
                            p = i;
                            break;
                        end
                    end
                    for (int i = list_len; i > p; i--) list_mem[i] = list_mem[i - 1];
                    list_mem[p] = v;
                    list_len++;
                end
            end
            OP_GET, OP_RM_AT: begin
                if (int'(idx) < lim && int'(idx) < list_len) begin
                    res.data = list_mem[idx];
                    if (op == OP_RM_AT) drop_entry(int'(idx));
                end else begin
                    res.status = ST_RANGE;
                end
            end
            default: begin
                res.status = ST_NOT_FOUND;
                for (int i = 0; i < list_len; i++) begin
                    if (list_mem[i] == v) begin
                        res.status   = ST_OK;
                        res.data     = v;
                        res.position = i[4:0];
                        drop_entry(i);
                        break;
                    end
                end
            end
        endcase
        res.count = list_len[5:0];
        return res;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return $urandom_range(0, 7) - 4;
        if (r < 45) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom();
    endfunction

    function automatic t_row cmd_row(t_op op, logic [31:0] v, logic [7:0] idx);
        t_row r;
        r       = '0;
        r.op    = op;
        r.value = v;
        r.index = idx;
        return r;
    endfunction

    function automatic t_row chk_row(t_op op, logic [31:0] v, logic [7:0] idx, t_status st,
                                     logic [31:0] d, logic [4:0] p, logic [5:0] n);
        t_row r;
        r                 = cmd_row(op, v, idx);
        r.typed           = 1'b1;
        r.want.status     = st;
        r.want.data       = d;
        r.want.position   = p;
        r.want.count      = n;
        return r;
    endfunction

    function automatic t_row cfg_row(logic [5:0] c);
        t_row r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.value  = 32'(c);
        return r;
    endfunction

    // one command transaction per call
    task automatic issue(t_op op, logic [31:0] v, logic [7:0] idx, logic typed, t_result want);
        int      gap;
        t_result got;
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_value     <= v;
        i_index     <= idx;
        do @(posedge i_clk); while (busy);
        got = list_apply(op, v, idx);
        pending.push_back(typed ? want : got);
    endtask

    task automatic set_capacity(logic [5:0] c);
        start <= 1'b0;
        while (pending.size() != 0 || busy) @(posedge i_clk);
        repeat (1 + idle_len()) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= c;
        do @(posedge i_clk); while (!o_cfg_ready);
        cap_reg = c;
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin : result_check
        t_result w;
        if (i_rst_n && o_done) begin
            if (pending.size() == 0) begin
                flag("result with no command pending", 32'(o_status), 32'd0);
            end else begin
                w = pending.pop_front();
                if (o_status !== w.status) flag("status", 32'(o_status), 32'(w.status));
                if (o_data !== w.data) flag("data", o_data, w.data);
                if (o_position !== w.position)
                    flag("position", 32'(o_position), 32'(w.position));
                if (o_count !== w.count) flag("count", 32'(o_count), 32'(w.count));
            end
        end
    end

    initial begin : stim
        t_row        plan [$];
        t_row        row;
        t_op         op;
        logic [31:0] v;
        logic [7:0]  idx;
        logic [5:0]  c;
        t_result     none;
        int          issued;
        int          ph;
        int          phase_len;
        int          add_pct;
        int          lim;
        int          r;

        none = '0;

        plan.push_back(chk_row(OP_GET,    0, 0, ST_RANGE, 0, 0, 0));
        plan.push_back(chk_row(OP_RM_AT,  0, 0, ST_RANGE, 0, 0, 0));
        plan.push_back(chk_row(OP_RM_VAL, 7, 0, ST_NOT_FOUND, 0, 0, 0));
        plan.push_back(chk_row(OP_ADD, 32'h0000_0000, 0, ST_OK, 0, 0, 1));
        plan.push_back(chk_row(OP_ADD, 32'h7fff_ffff, 0, ST_OK, 0, 0, 2));
        plan.push_back(chk_row(OP_ADD, 32'h8000_0000, 0, ST_OK, 0, 0, 3));
        plan.push_back(chk_row(OP_ADD, 32'hffff_ffff, 0, ST_OK, 0, 0, 4));
        plan.push_back(chk_row(OP_ADD, 32'h0000_0000, 0, ST_OK, 0, 0, 5));
        plan.push_back(chk_row(OP_ADD, 5, 0, ST_FULL, 0, 0, 5));
        plan.push_back(chk_row(OP_GET, 0, 0, ST_OK, 32'h8000_0000, 0, 5));
        plan.push_back(chk_row(OP_GET, 0, 4, ST_OK, 32'h7fff_ffff, 0, 5));
        plan.push_back(chk_row(OP_GET, 0, 5, ST_RANGE, 0, 0, 5));
        plan.push_back(chk_row(OP_GET, 0, 255, ST_RANGE, 0, 0, 5));
        plan.push_back(chk_row(OP_RM_VAL, 0, 0, ST_OK, 0, 2, 4));
        plan.push_back(chk_row(OP_RM_AT, 0, 0, ST_OK, 32'h8000_0000, 0, 3));
        plan.push_back(cmd_row(OP_RM_VAL, 32'hffff_ffff, 0));
        plan.push_back(chk_row(OP_RM_VAL, 12345, 0, ST_NOT_FOUND, 0, 0, 2));
        plan.push_back(cmd_row(OP_RM_AT, 0, 1));
        // stored zero read back and taken out
        plan.push_back(cmd_row(OP_RM_AT, 0, 0));
        plan.push_back(cfg_row(6'd0));
        plan.push_back(chk_row(OP_ADD, 9, 0, ST_FULL, 0, 0, 0));
        plan.push_back(cfg_row(6'd2));
        plan.push_back(cmd_row(OP_ADD, 3, 0));
        plan.push_back(cmd_row(OP_ADD, 1, 0));
        plan.push_back(chk_row(OP_ADD, 2, 0, ST_FULL, 0, 0, 2));
        // capacity below count
        plan.push_back(cfg_row(6'd1));
        plan.push_back(chk_row(OP_GET, 0, 1, ST_RANGE, 0, 0, 2));
        plan.push_back(cmd_row(OP_GET, 0, 0));
        plan.push_back(cmd_row(OP_RM_VAL, 3, 0));
        plan.push_back(cmd_row(OP_RM_AT, 0, 0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < plan.size(); k++) begin
            row = plan[k];
            if (row.is_cfg) set_capacity(row.value[5:0]);
            else issue(row.op, row.value, row.index, row.typed, row.want);
        end

        issued = 0;
        ph     = 0;
        while (issued < N_RANDOM) begin
            case (ph)
                0: c = 6'd32;
                1: c = 6'd63;
                2: c = 6'd0;
                3: c = 6'd1;
                default: begin
                    case ($urandom_range(0, 9))
                        0: c = 6'd0;
                        1: c = 6'd63;
                        2, 3: c = 6'd32;
                        4: c = 6'($urandom_range(33, 63));
                        default: c = 6'($urandom_range(1, 8));
                    endcase
                end
            endcase
            set_capacity(c);
            steady    = ($urandom_range(0, 4) == 0);
            add_pct   = (c >= 32) ? $urandom_range(45, 80) : $urandom_range(25, 65);
            phase_len = $urandom_range(40, 100);
            lim       = (c > DEPTH) ? DEPTH : int'(c);
            repeat (phase_len) begin
                r = $urandom_range(0, 99);
                v = pick_value();
                case ($urandom_range(0, 9))
                    0, 1: idx = 8'($urandom_range(0, 255));
                    2: idx = 8'(lim);
                    default: idx = 8'($urandom_range(0, list_len));
                endcase
                if (r < 5) begin
                    op  = t_op'($urandom_range(0, 3));
                    v   = $urandom();
                    idx = 8'($urandom_range(0, 255));
                end else if (r < 5 + add_pct) begin
                    op = OP_ADD;
                end else begin
                    case ($urandom_range(0, 2))
                        0: op = OP_GET;
                        1: op = OP_RM_AT;
                        default: op = OP_RM_VAL;
                    endcase
                    if (op == OP_RM_VAL && list_len > 0 && $urandom_range(0, 9) < 7)
                        v = list_mem[$urandom_range(0, list_len - 1)];
                end
                issue(op, v, idx, 1'b0, none);
                issued++;
            end
            ph++;
        end

        start <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #(8_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
